@@ rtl/sf3_pkg.sv @@
// ----------------------------------------------------------------------------
// sf3_pkg
// Types, constants and channel arithmetic for the 3x3 cross-kernel sharpen.
// ----------------------------------------------------------------------------
package sf3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int CFGW_W    = 11;
	localparam int CH_W      = 8;
	localparam int PX_W      = 3 * CH_W;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CFGW_W-1:0] WIDTH_RESET  = CFGW_W'(640);
	localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(480);

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic            frame_start;
	} pixel_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [CH_W-1:0]  red_out;
		logic [CH_W-1:0]  green_out;
		logic [CH_W-1:0]  blue_out;
		logic             last_of_run;
	} result_t;

	// 5*ctr - up - dn - lf - rt, clamped to the channel range
	function automatic logic [CH_W-1:0] sharpen_ch(
		input logic [CH_W-1:0] ctr,
		input logic [CH_W-1:0] up,
		input logic [CH_W-1:0] dn,
		input logic [CH_W-1:0] lf,
		input logic [CH_W-1:0] rt
	);
		logic [CH_W+3:0] v;
		logic [CH_W-1:0] res;
		v = {2'b00, ctr, 2'b00} + {4'b0000, ctr} - {4'b0000, up} - {4'b0000, dn}
			- {4'b0000, lf} - {4'b0000, rt};
		if (v[CH_W+3]) begin
			res = '0;
		end else if (|v[CH_W+2:CH_W]) begin
			res = '1;
		end else begin
			res = v[CH_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [PX_W-1:0] sharpen_px(
		input logic [PX_W-1:0] ctr,
		input logic [PX_W-1:0] up,
		input logic [PX_W-1:0] dn,
		input logic [PX_W-1:0] lf,
		input logic [PX_W-1:0] rt
	);
		logic [PX_W-1:0] res;
		for (int k = 0; k < 3; k++) begin
			res[k*CH_W +: CH_W] = sharpen_ch(ctr[k*CH_W +: CH_W], up[k*CH_W +: CH_W],
				dn[k*CH_W +: CH_W], lf[k*CH_W +: CH_W], rt[k*CH_W +: CH_W]);
		end
		return res;
	endfunction

endpackage

@@ rtl/sharpen_filter_3x3.sv @@
// ----------------------------------------------------------------------------
// sharpen_filter_3x3
// Streaming 3x3 cross-kernel sharpen of RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter at one per clock while pix_stall is low. Each accepted pixel
// reads the two line stores (one 1024 x 48 memory, one read and one write per
// cycle) into the input stage, is filtered there and lands in a two-slot
// registered result stage. A pixel that yields one or no result does not
// stall the input by itself; one that yields two (pixels of the last
// row and of the right column, from the third row and the third column on)
// holds both slots, so input is stalled while both are held. Border
// pixels come out as zero when they arrive; an interior pixel comes out when
// the pixel below and to its right arrives, ahead of that pixel's own border
// result. Writing either register or sending frame_start restarts the
// position at row 0, column 0.
// Registers: image_width at byte 0, image_height at byte 4.
// ----------------------------------------------------------------------------
module sharpen_filter_3x3 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  sf3_pkg::pixel_t                pix_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output sf3_pkg::result_t               res_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sf3_pkg::ADDR_W-1:0]     paddr,
	input  logic [sf3_pkg::DATA_W-1:0]     pwdata,
	output logic [sf3_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import sf3_pkg::*;

	logic [CFGW_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic [COL_W-1:0]  w_last;
	logic [ROW_W-1:0]  h_last;
	logic              cfg_wr;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  rd_col;
	logic [ROW_W-1:0]  rd_row;
	logic              pix_acc;

	logic [2*PX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PX_W-1:0] mem_rd_q;

	logic              vld_s1;
	logic [PX_W-1:0]   pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              byp_q;
	logic [PX_W-1:0]   byp_up_q;
	logic [PX_W-1:0]   byp_lo_q;
	logic [PX_W-1:0]   up_eff;
	logic [PX_W-1:0]   lo_eff;
	logic              adv_s1;

	logic [PX_W-1:0]   rec0_q;
	logic [PX_W-1:0]   rec1_q;
	logic [PX_W-1:0]   rec2_q;
	logic [PX_W-1:0]   prev_q;

	logic              inner;
	logic              border;
	result_t           res_a;
	result_t           res_b;

	result_t           a_s2;
	result_t           b_s2;
	logic              va_s2;
	logic              vb_s2;
	logic              s2_free;
	logic              res_acc;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_IMAGE_WIDTH:  prdata = DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFGW_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		priority if (width_q == '0) begin
			w_last = '0;
		end else if (width_q[CFGW_W-1] && (|width_q[CFGW_W-2:0])) begin
			w_last = '1;
		end else begin
			w_last = COL_W'(width_q - CFGW_W'(1));
		end
		h_last = (height_q == '0) ? '0 : height_q - ROW_W'(1);
	end

	// position and line memory read
	assign pix_stall = vld_s1 & ~s2_free;
	assign pix_acc   = pix_valid & ~pix_stall;
	assign rd_col    = pix_data.frame_start ? '0 : col_q;
	assign rd_row    = pix_data.frame_start ? '0 : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (rd_col == w_last) begin
				col_q <= '0;
				row_q <= (rd_row == h_last) ? '0 : rd_row + ROW_W'(1);
			end else begin
				col_q <= rd_col + COL_W'(1);
				row_q <= rd_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			mem_rd_q <= line_mem[rd_col];
		end
		if (adv_s1) begin
			line_mem[col_s1] <= {lo_eff, pix_s1};
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1   <= {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
			col_s1   <= rd_col;
			row_s1   <= rd_row;
			byp_q    <= adv_s1 && (col_s1 == rd_col);
			byp_up_q <= lo_eff;
			byp_lo_q <= pix_s1;
		end
	end

	assign up_eff = byp_q ? byp_up_q : mem_rd_q[2*PX_W-1:PX_W];
	assign lo_eff = byp_q ? byp_lo_q : mem_rd_q[PX_W-1:0];
	assign adv_s1 = vld_s1 & s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec0_q <= '0;
			rec1_q <= '0;
			rec2_q <= '0;
			prev_q <= '0;
		end else if (adv_s1) begin
			rec0_q <= up_eff;
			rec1_q <= rec2_q;
			rec2_q <= lo_eff;
			prev_q <= pix_s1;
		end
	end

	// filter
	always_comb begin
		logic [PX_W-1:0] px;
		px     = sharpen_px(rec2_q, rec0_q, prev_q, rec1_q, lo_eff);
		inner  = (|row_s1[ROW_W-1:1]) && (|col_s1[COL_W-1:1]);
		border = (row_s1 == '0) || (row_s1 == h_last) || (col_s1 == '0)
			|| (col_s1 == w_last);

		res_a.out_row     = row_s1 - ROW_W'(1);
		res_a.out_col     = col_s1 - COL_W'(1);
		res_a.red_out     = px[3*CH_W-1:2*CH_W];
		res_a.green_out   = px[2*CH_W-1:CH_W];
		res_a.blue_out    = px[CH_W-1:0];
		res_a.last_of_run = ~border;

		res_b.out_row     = row_s1;
		res_b.out_col     = col_s1;
		res_b.red_out     = '0;
		res_b.green_out   = '0;
		res_b.blue_out    = '0;
		res_b.last_of_run = 1'b1;
	end

	// result stage: interior result first, border result second
	assign res_valid = va_s2 | vb_s2;
	assign res_data  = va_s2 ? a_s2 : b_s2;
	assign res_acc   = res_valid & ~res_stall;
	assign s2_free   = ~(va_s2 | vb_s2) | (~res_stall & (va_s2 ^ vb_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s2 <= 1'b0;
			vb_s2 <= 1'b0;
		end else if (adv_s1) begin
			va_s2 <= inner;
			vb_s2 <= border;
		end else if (res_acc) begin
			if (va_s2) begin
				va_s2 <= 1'b0;
			end else begin
				vb_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			a_s2 <= res_a;
			b_s2 <= res_b;
		end
	end

endmodule
